// ===== hdl/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg : shared types and constants of the packet loss emulator
// Configuration register layout, queue entry and draw unit status types,
// generator and reduction constants.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Beat widths
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PROB_W     = 14;

  // MINSTD generator, modulus 2^31-1
  localparam logic [15:0] MINSTD_MUL = 16'd48271;
  localparam logic [30:0] MINSTD_MOD = 31'h7fff_ffff;

  // Draw range and rejection limit (largest multiple of the range below the modulus)
  localparam logic [13:0] DRAW_RANGE = 14'd10000;
  localparam logic [30:0] DRAW_LIMIT = 31'd2147480000;

  // x / 10000 = (x >> 4) / 625, done as a multiply by ceil(2^37 / 625) then >> 37
  localparam logic [27:0] RECIP_625   = 28'd219902326;
  localparam int unsigned RECIP_SHIFT = 37;

  localparam logic [7:0] PROTO_TCP = 8'h06;

  // Decoupling queue between classifier and loss engine
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WATCH_PROTOCOL  = 3'd0,
    CFG_WATCH_PORT      = 3'd1,
    CFG_ADDR_PAIR       = 3'd2,
    CFG_LOSS_MODE       = 3'd3,
    CFG_GOOD_STATE_LOSS = 3'd4,
    CFG_BAD_STATE_LOSS  = 3'd5,
    CFG_GOOD_TO_BAD     = 3'd6,
    CFG_BAD_TO_GOOD     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        watch_protocol;
    logic [15:0]       watch_port;
    logic [63:0]       addr_pair;
    logic              loss_mode;
    logic [PROB_W-1:0] good_state_loss;
    logic [PROB_W-1:0] bad_state_loss;
    logic [PROB_W-1:0] good_to_bad;
    logic [PROB_W-1:0] bad_to_good;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    watch_protocol:  PROTO_TCP,
    watch_port:      16'd6121,
    addr_pair:       64'd0,
    loss_mode:       1'b0,
    good_state_loss: 14'd500,
    bad_state_loss:  14'd10000,
    good_to_bad:     14'd0,
    bad_to_good:     14'd10000
  };

  // Queue entry: the classifier's verdict for one packet
  typedef struct packed {
    logic matched;
  } pkt_class_t;

  // Draw unit status towards the loss engine
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROB_W-1:0] value;
  } draw_stat_t;

endpackage

// ===== hdl/ple_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_front : packet classifier
// Accepts header beats and pushes the filter verdict into the queue.
// ----------------------------------------------------------------------------
module ple_front (
  input  ple_pkg::cfg_regs_t                   cfg,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ple_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                 q_full,
  output logic                                 q_push,
  output ple_pkg::pkt_class_t                  q_data
);
  import ple_pkg::*;

  logic [7:0]  ip_protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] addr_a;
  logic [31:0] addr_b;
  logic        proto_hit;
  logic        port_hit;
  logic        addr_hit;

  assign ip_protocol = in_tdata[7:0];
  assign src_addr    = in_tdata[39:8];
  assign dst_addr    = in_tdata[71:40];
  assign src_port    = in_tdata[87:72];
  assign dst_port    = in_tdata[103:88];

  assign addr_a = cfg.addr_pair[63:32];
  assign addr_b = cfg.addr_pair[31:0];

  assign proto_hit = (ip_protocol == cfg.watch_protocol);
  assign port_hit  = (src_port == cfg.watch_port) || (dst_port == cfg.watch_port);
  // address pair may appear in either direction
  assign addr_hit  = ((addr_a == src_addr) && (addr_b == dst_addr)) ||
                     ((addr_a == dst_addr) && (addr_b == src_addr));

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_data.matched = proto_hit && port_hit && addr_hit;

endmodule

// ===== hdl/ple_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_fifo : short verdict queue
// Decouples the classifier from the loss engine.
// ----------------------------------------------------------------------------
module ple_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ple_pkg::pkt_class_t wr_data,
  input  logic                pop,
  output ple_pkg::pkt_class_t rd_data,
  output logic                full,
  output logic                empty
);
  import ple_pkg::*;

  pkt_class_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/ple_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_draw : MINSTD draw unit
// Steps the generator with rejection, then reduces the last value mod 10000.
// ----------------------------------------------------------------------------
module ple_draw #(
  parameter int unsigned RNG_SEED     = 42,
  parameter int unsigned REJECT_TRIES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output ple_pkg::draw_stat_t stat
);
  import ple_pkg::*;

  localparam int unsigned TRY_W = $clog2(REJECT_TRIES + 1);

  typedef enum logic [6:0] {
    D_IDLE  = 7'b000_0001,
    D_MUL   = 7'b000_0010,
    D_FOLD  = 7'b000_0100,
    D_NORM  = 7'b000_1000,
    D_RECIP = 7'b001_0000,
    D_QMUL  = 7'b010_0000,
    D_REM   = 7'b100_0000
  } draw_state_t;

  draw_state_t       state_r, state_nxt;
  logic [30:0]       rng_r, rng_nxt;
  logic [TRY_W-1:0]  tries_r, tries_nxt;
  logic              done_r, done_nxt;
  logic [46:0]       prod_r, prod_nxt;
  logic [31:0]       sum_r, sum_nxt;
  logic [54:0]       recip_r, recip_nxt;
  logic [31:0]       qm_r, qm_nxt;
  logic [PROB_W-1:0] val_r, val_nxt;
  logic [31:0]       norm;
  logic [31:0]       diff;

  // Mersenne fold leaves the sum below twice the modulus: one subtract
  assign norm = (sum_r >= {1'b0, MINSTD_MOD}) ? sum_r - {1'b0, MINSTD_MOD} : sum_r;
  assign diff = {1'b0, rng_r} - qm_r;

  always_comb begin
    state_nxt = state_r;
    rng_nxt   = rng_r;
    tries_nxt = tries_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    recip_nxt = recip_r;
    qm_nxt    = qm_r;
    val_nxt   = val_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          if (rng_r == '0) begin
            rng_nxt = 31'(RNG_SEED);
          end
          tries_nxt = '0;
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        prod_nxt  = {16'd0, rng_r} * {31'd0, MINSTD_MUL};
        state_nxt = D_FOLD;
      end
      D_FOLD: begin
        sum_nxt   = {16'd0, prod_r[46:31]} + {1'b0, prod_r[30:0]};
        state_nxt = D_NORM;
      end
      D_NORM: begin
        rng_nxt   = norm[30:0];
        tries_nxt = tries_r + 1'b1;
        if ((norm[30:0] < DRAW_LIMIT) || (tries_r == TRY_W'(REJECT_TRIES - 1))) begin
          state_nxt = D_RECIP;
        end else begin
          state_nxt = D_MUL;
        end
      end
      D_RECIP: begin
        recip_nxt = {28'd0, rng_r[30:4]} * {27'd0, RECIP_625};
        state_nxt = D_QMUL;
      end
      D_QMUL: begin
        qm_nxt    = {14'd0, recip_r[54:RECIP_SHIFT]} * {18'd0, DRAW_RANGE};
        state_nxt = D_REM;
      end
      D_REM: begin
        val_nxt   = diff[PROB_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      rng_r   <= 31'(RNG_SEED);
      tries_r <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rng_r   <= rng_nxt;
      tries_r <= tries_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    recip_r <= recip_nxt;
    qm_r    <= qm_nxt;
    val_r   <= val_nxt;
  end

  assign stat.busy  = (state_r != D_IDLE);
  assign stat.done  = done_r;
  assign stat.value = val_r;

endmodule

// ===== hdl/ple_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_back : loss engine
// Pops verdicts, runs the uniform or two-state loss decision, holds the
// channel state and the result register.
// ----------------------------------------------------------------------------
module ple_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ple_pkg::cfg_regs_t             cfg,
  input  logic                           q_empty,
  input  ple_pkg::pkt_class_t            q_data,
  output logic                           q_pop,
  output logic                           draw_start,
  input  ple_pkg::draw_stat_t            draw,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ple_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ple_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_LOSS  = 4'b0010,
    B_TRANS = 4'b0100,
    B_DONE  = 4'b1000
  } back_state_t;

  back_state_t           state_r, state_nxt;
  logic                  bad_r, bad_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  drop_r, drop_nxt;
  logic                  match_r, match_nxt;
  logic [PROB_W-1:0]     thr_r, thr_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  hit;

  assign hit = (draw.value < thr_r);

  always_comb begin
    state_nxt     = state_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    drop_nxt      = drop_r;
    match_nxt     = match_r;
    thr_nxt       = thr_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    draw_start    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          match_nxt = q_data.matched;
          drop_nxt  = 1'b0;
          if (q_data.matched) begin
            draw_start = 1'b1;
            thr_nxt    = (cfg.loss_mode && bad_r) ? cfg.bad_state_loss : cfg.good_state_loss;
            state_nxt  = B_LOSS;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      B_LOSS: begin
        if (draw.done) begin
          drop_nxt = hit;
          if (cfg.loss_mode) begin
            draw_start = 1'b1;
            thr_nxt    = bad_r ? cfg.bad_to_good : cfg.good_to_bad;
            state_nxt  = B_TRANS;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      B_TRANS: begin
        if (draw.done) begin
          if (hit) begin
            bad_nxt = !bad_r;
          end
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, bad_r, match_r, drop_r};
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r     <= drop_nxt;
    match_r    <= match_nxt;
    thr_r      <= thr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/packet_loss_emulator_core.sv =====
`timescale 1ns / 1ps
// Flow: an unmatched packet goes through the verdict queue and the engine's done state to
//   the result register; a matched packet also waits for its draws, each of 1 to
//   REJECT_TRIES generator steps and a reduction. Uniform mode makes one draw,
//   two-state mode two. The engine takes one packet at a time; the queue holds two more.
// Reset (synchronous, rst_n low): registers to defaults, generator to RNG_SEED,
//   channel good, queue and result register empty.
// ----------------------------------------------------------------------------
// packet_loss_emulator_core : packet loss emulator top level
// Header beats in, one drop/matched/state beat out per packet. A classifier
// feeds a two-entry queue; the loss engine drains it using a MINSTD draw unit.
// ----------------------------------------------------------------------------
module packet_loss_emulator_core #(
  parameter int unsigned RNG_SEED     = 42,
  parameter int unsigned REJECT_TRIES = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beat
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] ip_protocol, [39:8] src_addr, [71:40] dst_addr,
  // [87:72] src_port, [103:88] dst_port
  input  logic [ple_pkg::IN_DATA_W-1:0]  in_tdata,
  // result beat
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] drop, [1] matched, [2] in_bad_state, [7:3] zero
  output logic [ple_pkg::OUT_DATA_W-1:0] out_tdata,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ple_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ple_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ple_pkg::*;

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  pkt_class_t q_wr_data;
  pkt_class_t q_rd_data;
  logic       draw_start;
  draw_stat_t draw_stat;

  // Registers are always writable; writes are expected only while no packet is in flight.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WATCH_PROTOCOL:  cfg_nxt.watch_protocol  = cfg_data[7:0];
        CFG_WATCH_PORT:      cfg_nxt.watch_port      = cfg_data[15:0];
        CFG_ADDR_PAIR:       cfg_nxt.addr_pair       = cfg_data;
        CFG_LOSS_MODE:       cfg_nxt.loss_mode       = cfg_data[0];
        CFG_GOOD_STATE_LOSS: cfg_nxt.good_state_loss = cfg_data[PROB_W-1:0];
        CFG_BAD_STATE_LOSS:  cfg_nxt.bad_state_loss  = cfg_data[PROB_W-1:0];
        CFG_GOOD_TO_BAD:     cfg_nxt.good_to_bad     = cfg_data[PROB_W-1:0];
        CFG_BAD_TO_GOOD:     cfg_nxt.bad_to_good     = cfg_data[PROB_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: filter on protocol, port and address pair
  ple_front u_front (
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // Verdict queue lets the front keep taking beats while a draw runs
  ple_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Generator and reduction; owns the generator state
  ple_draw #(
    .RNG_SEED     (RNG_SEED),
    .REJECT_TRIES (REJECT_TRIES)
  ) u_draw (
    .clk   (clk),
    .rst_n (rst_n),
    .start (draw_start),
    .stat  (draw_stat)
  );

  // Back: loss decision, channel state, result register
  ple_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .draw_start (draw_start),
    .draw       (draw_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // An unmatched packet is never dropped
  a_unmatched_passes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> !out_tdata[0])
    else $error("unmatched packet flagged for drop");

  // The engine never restarts a draw that is still running
  a_no_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    draw_start |-> !draw_stat.busy)
    else $error("draw started while draw unit busy");

  // The front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("verdict queue overflow");

  // Reduced draws stay inside the draw range
  a_draw_range : assert property (@(posedge clk) disable iff (!rst_n)
    draw_stat.done |-> (draw_stat.value < DRAW_RANGE))
    else $error("draw value out of range");

endmodule
